### rtl/spsa_pkg.sv
package spsa_pkg;

	// Operation codes carried in the opcode field
	localparam logic [2:0] OP_BEGIN  = 3'd0;
	localparam logic [2:0] OP_PLACE  = 3'd1;
	localparam logic [2:0] OP_END    = 3'd2;
	localparam logic [2:0] OP_VBLANK = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	// Configuration register indexes
	localparam logic CFG_SLOT_MASK   = 1'b0;
	localparam logic CFG_EARLY_LINES = 1'b1;

	// Table geometry: one row holds every slot lane of one scanline
	localparam int SLOT_LANES = 16;
	localparam int ROW_W      = SLOT_LANES * 8;

	localparam logic [7:0] EMPTY   = 8'hFF;
	localparam logic [4:0] NO_SLOT = 5'd16;

	typedef struct packed {
		logic [2:0]        opcode;
		logic signed [15:0] sprite_y;
		logic signed [7:0]  top_offset;
		logic signed [7:0]  bottom_offset;
		logic              hidden;
		logic [7:0]        palette_number;
		logic [7:0]        line;
		logic [3:0]        slot;
	} in_item_t;

	typedef struct packed {
		logic [4:0] assigned_slot;
		logic [7:0] entry;
		logic       live_buffer;
	} out_item_t;

	// Row span of one placement, handed from the span unit to the sequencer
	typedef struct packed {
		logic       ok;
		logic [7:0] start;
		logic [7:0] stop;
	} span_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SPAN,
		ST_LOOK,
		ST_PICK,
		ST_FILL,
		ST_CLEAR,
		ST_RDWAIT,
		ST_DONE
	} state_t;

endpackage

### rtl/spsa_line_ram.sv
module spsa_line_ram #(
	parameter int AW = 9
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              wr_addr,
	input  logic [spsa_pkg::SLOT_LANES-1:0] wr_be,
	input  logic [spsa_pkg::ROW_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [spsa_pkg::ROW_W-1:0] rd_data
);

	logic [spsa_pkg::ROW_W-1:0] mem [2**AW];

	// Write the enabled byte lanes of one row
	always_ff @(posedge clk) begin
		if (we) begin
			for (int k = 0; k < spsa_pkg::SLOT_LANES; k++) begin
				if (wr_be[k]) begin
					mem[wr_addr][k*8 +: 8] <= wr_data[k*8 +: 8];
				end
			end
		end
	end

	// Register the read row
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/spsa_span.sv
module spsa_span #(
	parameter int LINES    = 160,
	parameter int PALETTES = 32
) (
	input  logic               clk,
	input  logic               en,
	input  spsa_pkg::in_item_t item,
	input  logic [2:0]         early_lines,
	output spsa_pkg::span_t    span
);

	localparam logic signed [16:0] LINES_S = 17'(LINES);
	localparam logic [7:0]         LINES_B = 8'(LINES);
	localparam logic [7:0]         PAL_B   = 8'(PALETTES);

	logic signed [16:0] top_sum;
	logic signed [16:0] bot_sum;
	logic [7:0]         top;
	logic [7:0]         bot;
	logic [7:0]         start;
	spsa_pkg::span_t    span_d;

	// Add offsets to the position and clamp both ends to the table
	always_comb begin
		top_sum = 17'(item.sprite_y) + 17'(item.top_offset);
		bot_sum = 17'(item.sprite_y) + 17'(item.bottom_offset);
		if (top_sum < 17'sd0) begin
			top = 8'd0;
		end else if (top_sum > LINES_S) begin
			top = LINES_B;
		end else begin
			top = top_sum[7:0];
		end
		if (bot_sum < 17'sd0) begin
			bot = 8'd0;
		end else if (bot_sum > LINES_S) begin
			bot = LINES_B;
		end else begin
			bot = bot_sum[7:0];
		end
		// Pull the start up by the early rows only when it stays on the table
		if (top >= {5'd0, early_lines}) begin
			start = top - {5'd0, early_lines};
		end else begin
			start = top;
		end
		span_d.ok    = !item.hidden && (top != bot) && (item.palette_number < PAL_B)
			&& (start < LINES_B);
		span_d.start = start;
		span_d.stop  = bot;
	end

	// Hold the span for the rest of the placement
	always_ff @(posedge clk) begin
		if (en) begin
			span <= span_d;
		end
	end

endmodule

### rtl/scanline_palette_slot_allocator.sv
// Double-buffered scanline palette slot table. Every beat on the item channel yields exactly one
// result beat. Begin frame refills the staging buffer with empty (255), one row per cycle. Place
// sprite writes its palette number on the chosen slot lane down its span, and writes nothing
// when its span is rejected or no slot is free; read entry returns empty when the line or slot
// lies off the table. The single table memory writes one row and reads one row per cycle. The
// result register frees the item side: a new item is taken while the previous result still
// waits. After reset the block clears both buffers, one row per cycle, and accepts no item
// meanwhile; configuration writes are taken at any time.
module scanline_palette_slot_allocator #(
	parameter int LINES    = 160,
	parameter int SLOTS    = 16,
	parameter int PALETTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                item_valid,
	output logic                item_ready,
	input  spsa_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output spsa_pkg::out_item_t result
);

	localparam int LINE_AW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int RAM_AW  = LINE_AW + 1;
	localparam logic [7:0] LAST_ROW = 8'(LINES - 1);
	localparam logic [spsa_pkg::SLOT_LANES-1:0] SLOT_EN =
		spsa_pkg::SLOT_LANES'((32'd1 << SLOTS) - 32'd1);

	spsa_pkg::state_t   state_q, state_d;
	spsa_pkg::in_item_t item_q;
	spsa_pkg::span_t    span;
	spsa_pkg::out_item_t result_q;

	logic        live_q;
	logic        busy_q;
	logic [15:0] slot_mask_q;
	logic [2:0]  early_q;
	logic [7:0]  row_q;
	logic        init_buf_q;
	logic        result_valid_q;
	logic [3:0]  slot_q;
	logic [4:0]  res_slot_q;
	logic [7:0]  res_entry_q;

	logic accept;
	logic rd_ok;
	logic row_last;
	logic fill_last;
	logic out_free;

	logic                            ram_we;
	logic [RAM_AW-1:0]               wr_addr;
	logic [spsa_pkg::SLOT_LANES-1:0] wr_be;
	logic [spsa_pkg::ROW_W-1:0]      wr_data;
	logic                            rd_en;
	logic [RAM_AW-1:0]               rd_addr;
	logic [spsa_pkg::ROW_W-1:0]      rd_data;

	logic [spsa_pkg::SLOT_LANES-1:0] cand;
	logic                            found;
	logic [3:0]                      pick;

	spsa_line_ram #(
		.AW(RAM_AW)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (wr_addr),
		.wr_be   (wr_be),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	spsa_span #(
		.LINES   (LINES),
		.PALETTES(PALETTES)
	) u_span (
		.clk        (clk),
		.en         (state_q == spsa_pkg::ST_SPAN),
		.item       (item_q),
		.early_lines(early_q),
		.span       (span)
	);

	// Decode conditions shared by the state machine and the datapath
	always_comb begin
		accept    = item_valid && item_ready;
		rd_ok     = (item.line < 8'(LINES)) && ({1'b0, item.slot} < 5'(SLOTS));
		row_last  = (row_q == LAST_ROW);
		fill_last = ({1'b0, row_q} + 9'd1) >= {1'b0, span.stop};
		out_free  = !result_valid_q || result_ready;
	end

	// Find the lowest allowed slot that is empty on the start row
	always_comb begin
		for (int j = 0; j < spsa_pkg::SLOT_LANES; j++) begin
			cand[j] = slot_mask_q[j] && SLOT_EN[j] && (rd_data[j*8 +: 8] == spsa_pkg::EMPTY);
		end
		found = |cand;
		pick  = 4'd0;
		for (int j = spsa_pkg::SLOT_LANES - 1; j >= 0; j--) begin
			if (cand[j]) begin
				pick = 4'(j);
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spsa_pkg::ST_INIT: begin
				if (row_last && init_buf_q) begin
					state_d = spsa_pkg::ST_IDLE;
				end
			end
			spsa_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (item.opcode)
						spsa_pkg::OP_BEGIN: state_d = spsa_pkg::ST_CLEAR;
						spsa_pkg::OP_PLACE: state_d = spsa_pkg::ST_SPAN;
						spsa_pkg::OP_READ:  state_d = rd_ok ? spsa_pkg::ST_RDWAIT
							: spsa_pkg::ST_DONE;
						default:            state_d = spsa_pkg::ST_DONE;
					endcase
				end
			end
			spsa_pkg::ST_SPAN:   state_d = spsa_pkg::ST_LOOK;
			spsa_pkg::ST_LOOK:   state_d = span.ok ? spsa_pkg::ST_PICK : spsa_pkg::ST_DONE;
			spsa_pkg::ST_PICK:   state_d = found ? spsa_pkg::ST_FILL : spsa_pkg::ST_DONE;
			spsa_pkg::ST_FILL: begin
				if (fill_last) begin
					state_d = spsa_pkg::ST_DONE;
				end
			end
			spsa_pkg::ST_CLEAR: begin
				if (row_last) begin
					state_d = spsa_pkg::ST_DONE;
				end
			end
			spsa_pkg::ST_RDWAIT: state_d = spsa_pkg::ST_DONE;
			spsa_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = spsa_pkg::ST_IDLE;
				end
			end
			default: state_d = spsa_pkg::ST_INIT;
		endcase
	end

	// Drive the handshake and the memory ports from the state
	always_comb begin
		item_ready = (state_q == spsa_pkg::ST_IDLE);
		ram_we     = 1'b0;
		wr_addr    = {~live_q, row_q[LINE_AW-1:0]};
		wr_be      = '1;
		wr_data    = {spsa_pkg::SLOT_LANES{spsa_pkg::EMPTY}};
		rd_en      = 1'b0;
		rd_addr    = {live_q, item.line[LINE_AW-1:0]};
		unique case (state_q)
			spsa_pkg::ST_INIT: begin
				ram_we  = 1'b1;
				wr_addr = {init_buf_q, row_q[LINE_AW-1:0]};
			end
			spsa_pkg::ST_IDLE: begin
				rd_en = accept && (item.opcode == spsa_pkg::OP_READ) && rd_ok;
			end
			spsa_pkg::ST_LOOK: begin
				rd_en   = span.ok;
				rd_addr = {~live_q, span.start[LINE_AW-1:0]};
			end
			spsa_pkg::ST_FILL: begin
				ram_we  = 1'b1;
				wr_be   = spsa_pkg::SLOT_LANES'(1) << slot_q;
				wr_data = {spsa_pkg::SLOT_LANES{item_q.palette_number}};
			end
			spsa_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control state: registers, buffer select, busy mark, row counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= spsa_pkg::ST_INIT;
			live_q         <= 1'b1;
			busy_q         <= 1'b0;
			slot_mask_q    <= 16'd0;
			early_q        <= 3'd2;
			row_q          <= 8'd0;
			init_buf_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					spsa_pkg::CFG_SLOT_MASK:   slot_mask_q <= cfg_data;
					spsa_pkg::CFG_EARLY_LINES: early_q     <= cfg_data[2:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				unique case (item.opcode)
					spsa_pkg::OP_BEGIN: begin
						busy_q <= 1'b1;
						row_q  <= 8'd0;
					end
					spsa_pkg::OP_END: busy_q <= 1'b0;
					spsa_pkg::OP_VBLANK: begin
						if (!busy_q) begin
							live_q <= ~live_q;
						end
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				spsa_pkg::ST_INIT: begin
					if (row_last) begin
						row_q      <= 8'd0;
						init_buf_q <= 1'b1;
					end else begin
						row_q <= row_q + 8'd1;
					end
				end
				spsa_pkg::ST_PICK:  row_q <= span.start;
				spsa_pkg::ST_FILL:  row_q <= row_q + 8'd1;
				spsa_pkg::ST_CLEAR: row_q <= row_q + 8'd1;
				default: begin
				end
			endcase
			// Load the result beat when done, drop it once taken
			if (state_q == spsa_pkg::ST_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload: captured item, chosen slot and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q      <= item;
			res_slot_q  <= spsa_pkg::NO_SLOT;
			res_entry_q <= spsa_pkg::EMPTY;
		end
		if (state_q == spsa_pkg::ST_PICK && found) begin
			slot_q     <= pick;
			res_slot_q <= {1'b0, pick};
		end
		if (state_q == spsa_pkg::ST_RDWAIT) begin
			res_entry_q <= rd_data[{item_q.slot, 3'b000} +: 8];
		end
		if (state_q == spsa_pkg::ST_DONE && out_free) begin
			result_q.assigned_slot <= res_slot_q;
			result_q.entry         <= res_entry_q;
			result_q.live_buffer   <= live_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Table writes after the reset sweep only ever touch the staging buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != spsa_pkg::ST_INIT) |-> (wr_addr[RAM_AW-1] == ~live_q))
		else $error("table write hit the live buffer");

	// The live buffer flips only on an accepted vblank outside a busy frame
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(live_q) |-> $past(accept && item.opcode == spsa_pkg::OP_VBLANK && !busy_q))
		else $error("live buffer flipped without a vblank");

	// Fill rows stay on the table
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spsa_pkg::ST_FILL) |-> (row_q < 8'(LINES)))
		else $error("fill row past the table");

	// A staging clear runs only inside a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spsa_pkg::ST_CLEAR) |-> busy_q)
		else $error("staging clear without busy mark");

	// A result beat appears only when an item completes
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == spsa_pkg::ST_DONE))
		else $error("result beat without a finished item");

endmodule
